@@ hdl/pims_pkg.sv @@
// Shared constants, types and helpers for the parallel iterative matching scheduler.
// No dependencies; used by pims_draw and the top level.
package pims_pkg;

  localparam int NUM_INPUTS  = 8;
  localparam int NUM_OUTPUTS = 8;
  localparam int MAX_PORTS   = 8;
  localparam int PORT_W      = 3;
  localparam int CNT_W       = 4;
  localparam int REQ_STRIDE  = 8;
  localparam int REQ_W       = 64;
  localparam int ITER_W      = 5;
  localparam int RNG_W       = 48;
  localparam int RNG_DEPTH   = NUM_OUTPUTS + NUM_INPUTS;
  localparam int RNG_AW      = $clog2(RNG_DEPTH);

  localparam logic [ITER_W-1:0] MAX_ROUNDS = 5'd16;
  localparam logic [RNG_W-1:0]  LCG_MUL    = 48'h0005_DEEC_E66D;
  localparam logic [RNG_W-1:0]  LCG_ADD    = 48'h0000_0000_000B;

  localparam logic [15:0] OUT_SEED_HI  = 16'h93ac;
  localparam logic [15:0] OUT_SEED_MID = 16'hbc21;
  localparam logic [15:0] OUT_SEED_LO  = 16'h1438;
  localparam logic [15:0] IN_SEED_HI   = 16'h90aa;
  localparam logic [15:0] IN_SEED_MID  = 16'hbe22;
  localparam logic [15:0] IN_SEED_LO   = 16'h1239;

  typedef struct packed {
    logic               start;
    logic [RNG_W-1:0]   x;
    logic [CNT_W-1:0]   count;
  } draw_req_t;

  typedef struct packed {
    logic               done;
    logic [RNG_W-1:0]   x_new;
    logic [PORT_W-1:0]  pick;
  } draw_rsp_t;

  // Generator seed for one port
  function automatic logic [RNG_W-1:0] seed_of(input logic [15:0] hi, input logic [15:0] mid,
                                               input logic [15:0] lo,
                                               input logic [PORT_W-1:0] p);
    logic [15:0] pe;
    pe = {{(16-PORT_W){1'b0}}, p};
    return {hi ^ pe, mid ^ pe, lo ^ pe};
  endfunction

  // Number of set bits in a candidate mask
  function automatic logic [CNT_W-1:0] popcount(input logic [MAX_PORTS-1:0] m);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_PORTS; i++) n = n + CNT_W'(m[i]);
    return n;
  endfunction

  // Position of the k-th set bit, counting from bit 0
  function automatic logic [PORT_W-1:0] pick_bit(input logic [MAX_PORTS-1:0] m,
                                                 input logic [PORT_W-1:0] k);
    logic [CNT_W-1:0]  seen;
    logic [PORT_W-1:0] res;
    seen = '0;
    res  = '0;
    for (int i = 0; i < MAX_PORTS; i++) begin
      if (m[i]) begin
        if (seen == {1'b0, k}) res = PORT_W'(i);
        seen = seen + 1'b1;
      end
    end
    return res;
  endfunction

endpackage

@@ hdl/pims_draw.sv @@
// Random draw unit: one 48-bit LCG step in partial products, then result mod count.
// Depends on pims_pkg.
module pims_draw (
  input  logic                clk,
  input  logic                rst_n,
  input  pims_pkg::draw_req_t req,
  output pims_pkg::draw_rsp_t rsp
);
  import pims_pkg::*;

  localparam logic [2:0] D_IDLE = 3'd0;
  localparam logic [2:0] D_MLO  = 3'd1;
  localparam logic [2:0] D_MHI  = 3'd2;
  localparam logic [2:0] D_SUM  = 3'd3;
  localparam logic [2:0] D_MOD  = 3'd4;

  logic [2:0]       dstate_r;
  logic [RNG_W-1:0] x_r;
  logic [CNT_W-1:0] cnt_r;
  logic [RNG_W-1:0] plo_r;
  logic [23:0]      phi_r;
  logic [31:0]      r_r;
  logic [CNT_W-1:0] rem_r;
  logic [2:0]       step_r;
  logic             done_r;
  logic [RNG_W-1:0] x_sum;
  logic [CNT_W-1:0] rem_nxt;

  // Next generator state from the two partial products
  assign x_sum = plo_r + {phi_r, 24'd0} + LCG_ADD;

  // Fold four bits of the draw into the running remainder
  always_comb begin
    rem_nxt = rem_r;
    for (int b = 0; b < 4; b++) begin
      rem_nxt = {rem_nxt[CNT_W-2:0], r_r[31-b]};
      if (rem_nxt >= cnt_r) rem_nxt = rem_nxt - cnt_r;
    end
  end

  // Step through multiply and remainder phases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dstate_r <= D_IDLE;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (dstate_r)
        D_IDLE: begin
          if (req.start) begin
            x_r      <= req.x;
            cnt_r    <= req.count;
            dstate_r <= D_MLO;
          end
        end
        D_MLO: begin
          plo_r    <= {24'd0, x_r[23:0]} * LCG_MUL;
          dstate_r <= D_MHI;
        end
        D_MHI: begin
          phi_r    <= x_r[47:24] * LCG_MUL[23:0];
          dstate_r <= D_SUM;
        end
        D_SUM: begin
          x_r      <= x_sum;
          r_r      <= {1'b0, x_sum[47:17]};
          rem_r    <= '0;
          step_r   <= '0;
          dstate_r <= D_MOD;
        end
        D_MOD: begin
          rem_r  <= rem_nxt;
          r_r    <= {r_r[27:0], 4'd0};
          step_r <= step_r + 1'b1;
          if (step_r == 3'd7) begin
            done_r   <= 1'b1;
            dstate_r <= D_IDLE;
          end
        end
        default: dstate_r <= D_IDLE;
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.x_new = x_r;
  assign rsp.pick  = rem_r[PORT_W-1:0];

endmodule

@@ hdl/parallel_iterative_matching_scheduler_top.sv @@
// Parallel iterative matching scheduler, top level: sequencer, generator memory, result port.
// Depends on pims_pkg and pims_draw.
//
// One request matrix word is taken at a time. After reset a pass loads the generator
// seeds into the generator memory and the input stays not ready. Matching then runs port by
// port: each grant round visits the 8 outputs and each accept round the 8 inputs; a port with
// no candidates is skipped in its scan step, and a port that draws goes through a memory read, two
// partial-product multiply steps, a sum step and an 8-step remainder in the draw unit. With a
// round limit of zero the item goes straight to the results. Eight result words follow, one
// per output in ascending order, each held until taken.
module parallel_iterative_matching_scheduler_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [pims_pkg::REQ_W-1:0]            in_request_matrix,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [pims_pkg::PORT_W-1:0]           out_output_port,
  output logic                                  out_matched,
  output logic [pims_pkg::PORT_W-1:0]           out_matched_input,
  output logic [pims_pkg::ITER_W-1:0]           out_rounds_used,
  output logic                                  out_last,
  input  logic                                  cfg_wr_en,
  input  logic [pims_pkg::ITER_W-1:0]           cfg_wr_data
);
  import pims_pkg::*;

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]              state_r;
  logic [RNG_AW-1:0]       init_cnt_r;
  logic [ITER_W-1:0]       cfg_iter_r;
  logic [REQ_W-1:0]        req_r;
  logic [ITER_W-1:0]       limit_r;
  logic [ITER_W-1:0]       round_r;
  logic [ITER_W-1:0]       rounds_r;
  logic                    phase_r;
  logic [PORT_W-1:0]       port_r;
  logic                    conn_r;
  logic [MAX_PORTS-1:0]    mask_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [PORT_W-1:0]       emit_r;

  logic [NUM_OUTPUTS-1:0]  grant_r   [NUM_INPUTS];
  logic                    in_vld_r  [NUM_INPUTS];
  logic                    out_vld_r [NUM_OUTPUTS];
  logic [PORT_W-1:0]       out_idx_r [NUM_OUTPUTS];

  logic [RNG_W-1:0]        rng_mem   [RNG_DEPTH];
  logic [RNG_W-1:0]        rd_data_r;

  logic [ITER_W-1:0]       lim;
  logic [MAX_PORTS-1:0]    scan_mask;
  logic                    scan_skip;
  logic [RNG_AW-1:0]       cur_addr;
  logic                    mem_we;
  logic [RNG_AW-1:0]       mem_waddr;
  logic [RNG_W-1:0]        mem_wdata;
  logic [RNG_W-1:0]        seed;
  logic                    draw_done;
  logic                    adv;
  logic                    conn_now;
  logic [PORT_W-1:0]       sel;
  draw_req_t               dreq;
  draw_rsp_t               drsp;

  // Saturate the round limit
  assign lim = (cfg_iter_r > MAX_ROUNDS) ? MAX_ROUNDS : cfg_iter_r;

  // Candidates of the current port
  always_comb begin
    scan_mask = '0;
    if (phase_r) begin
      scan_skip = in_vld_r[port_r];
      for (int o = 0; o < NUM_OUTPUTS; o++) scan_mask[o] = grant_r[port_r][o];
    end else begin
      scan_skip = out_vld_r[port_r];
      for (int i = 0; i < NUM_INPUTS; i++)
        scan_mask[i] = req_r[i*REQ_STRIDE + int'(port_r)] & ~in_vld_r[i];
    end
    if (scan_mask == '0) scan_skip = 1'b1;
  end

  // Outputs live at the low addresses, inputs above them
  assign cur_addr = phase_r ? RNG_AW'(NUM_OUTPUTS) + RNG_AW'(port_r) : RNG_AW'(port_r);

  // Seed for the loading pass after reset
  always_comb begin
    if (init_cnt_r < RNG_AW'(NUM_OUTPUTS))
      seed = seed_of(OUT_SEED_HI, OUT_SEED_MID, OUT_SEED_LO, PORT_W'(init_cnt_r));
    else
      seed = seed_of(IN_SEED_HI, IN_SEED_MID, IN_SEED_LO,
                     PORT_W'(init_cnt_r - RNG_AW'(NUM_OUTPUTS)));
  end

  assign draw_done = (state_r == ST_WAIT) && drsp.done;
  assign sel       = pick_bit(mask_r, drsp.pick);
  assign mem_we    = (state_r == ST_INIT) || draw_done;
  assign mem_waddr = (state_r == ST_INIT) ? init_cnt_r : cur_addr;
  assign mem_wdata = (state_r == ST_INIT) ? seed : drsp.x_new;
  assign adv       = ((state_r == ST_SCAN) && scan_skip) || draw_done;
  assign conn_now  = conn_r || (draw_done && phase_r);

  // Generator memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) rng_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= rng_mem[cur_addr];
  end

  assign dreq.start = (state_r == ST_READ);
  assign dreq.x     = rd_data_r;
  assign dreq.count = cnt_r;

  pims_draw u_draw (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      init_cnt_r <= '0;
      cfg_iter_r <= ITER_W'(1);
    end else begin
      if (cfg_wr_en) cfg_iter_r <= cfg_wr_data;
      unique case (state_r)
        ST_INIT: begin
          init_cnt_r <= init_cnt_r + 1'b1;
          if (init_cnt_r == RNG_AW'(RNG_DEPTH - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) begin
            req_r   <= in_request_matrix;
            round_r <= '0;
            phase_r <= 1'b0;
            port_r  <= '0;
            conn_r  <= 1'b0;
            limit_r <= lim;
            emit_r  <= '0;
            for (int i = 0; i < NUM_INPUTS; i++) begin
              grant_r[i]  <= '0;
              in_vld_r[i] <= 1'b0;
            end
            for (int o = 0; o < NUM_OUTPUTS; o++) begin
              out_vld_r[o] <= 1'b0;
              out_idx_r[o] <= '0;
            end
            if (lim == '0) begin
              rounds_r <= '0;
              state_r  <= ST_EMIT;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (!scan_skip) begin
            mask_r  <= scan_mask;
            cnt_r   <= popcount(scan_mask);
            state_r <= ST_READ;
          end
        end
        ST_READ: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (drsp.done) begin
            if (phase_r) begin
              in_vld_r[port_r] <= 1'b1;
              out_vld_r[sel]   <= 1'b1;
              out_idx_r[sel]   <= port_r;
              conn_r           <= 1'b1;
            end else begin
              grant_r[sel][port_r] <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            if (emit_r == PORT_W'(NUM_OUTPUTS - 1)) state_r <= ST_IDLE;
            else emit_r <= emit_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      // Advance to the next port, phase or round
      if (adv) begin
        state_r <= ST_SCAN;
        if (!phase_r) begin
          if (port_r == PORT_W'(NUM_OUTPUTS - 1)) begin
            phase_r <= 1'b1;
            port_r  <= '0;
          end else begin
            port_r <= port_r + 1'b1;
          end
        end else if (port_r == PORT_W'(NUM_INPUTS - 1)) begin
          if (!conn_now) begin
            rounds_r <= round_r;
            state_r  <= ST_EMIT;
          end else if (round_r + 1'b1 == limit_r) begin
            rounds_r <= limit_r;
            state_r  <= ST_EMIT;
          end else begin
            round_r <= round_r + 1'b1;
            phase_r <= 1'b0;
            port_r  <= '0;
            conn_r  <= 1'b0;
          end
        end else begin
          port_r <= port_r + 1'b1;
        end
      end
    end
  end

  // Result word, held while the emit state waits
  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = (state_r == ST_EMIT);
  assign out_output_port   = emit_r;
  assign out_matched       = out_vld_r[emit_r];
  assign out_matched_input = out_vld_r[emit_r] ? out_idx_r[emit_r] : '0;
  assign out_rounds_used   = rounds_r;
  assign out_last          = (emit_r == PORT_W'(NUM_OUTPUTS - 1));

endmodule
